### hdl/gcd_pkg.sv
// Shared widths, fixed-point constants and the arctangent table for the distance pipeline.
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

    // Datapath widths.
    localparam int ROT_W     = 34;   // rotation CORDIC x, y, z and Q30 products
    localparam int VEC_W     = 38;   // vectoring CORDIC x and y
    localparam int ANG_W     = 34;   // central angle, Q30 radians, signed
    localparam int C_W       = 35;   // cosine term and cross term after the sums
    localparam int SQ_IN_W   = 64;   // sum of squares
    localparam int SQ_OUT_W  = 32;   // its integer root
    localparam int ATAN_N    = 32;   // entries in the arctangent table

    // Lanes of the rotation CORDIC.
    localparam int ROT_LANES = 3;
    localparam int LANE_LAT1 = 0;
    localparam int LANE_LAT2 = 1;
    localparam int LANE_DLON = 2;

    // pi/180 in Q40, split so that each partial product stays narrow.
    localparam logic [34:0] DEG2RAD_Q40 = 35'd19190098069;
    localparam int          DEG2RAD_LO_W = 18;
    localparam logic [17:0] DEG2RAD_LO = DEG2RAD_Q40[17:0];
    localparam logic [16:0] DEG2RAD_HI = DEG2RAD_Q40[34:18];

    // CORDIC start gain and a quarter turn, both Q30.
    localparam logic signed [ROT_W-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // atan(2^-i) in Q30.
    localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // Q30 product, floored.
    function automatic logic signed [ROT_W-1:0] mulq(input logic signed [ROT_W-1:0] a,
                                                     input logic signed [ROT_W-1:0] b);
        logic signed [2*ROT_W-1:0] p;
        p = a * b;
        return p[30+ROT_W-1:30];
    endfunction

endpackage

`default_nettype wire

### hdl/gcd_cordic_rot.sv
// Pipelined rotation CORDIC giving the cosine and sine of three angles in parallel.
`timescale 1ns / 1ps
`default_nettype none

module gcd_cordic_rot #(
    parameter int STAGES = 24,
    parameter int SIDE_W = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [gcd_pkg::ROT_W-1:0]   i_angle [gcd_pkg::ROT_LANES],
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic signed [gcd_pkg::ROT_W-1:0]   o_cos [gcd_pkg::ROT_LANES],
    output logic signed [gcd_pkg::ROT_W-1:0]   o_sin [gcd_pkg::ROT_LANES],
    output logic [SIDE_W-1:0]                  o_side
);

    logic                             r_valid [STAGES+1];
    logic [SIDE_W-1:0]                r_side  [STAGES+1];
    logic signed [gcd_pkg::ROT_W-1:0] r_x [STAGES+1][gcd_pkg::ROT_LANES];
    logic signed [gcd_pkg::ROT_W-1:0] r_y [STAGES+1][gcd_pkg::ROT_LANES];
    logic signed [gcd_pkg::ROT_W-1:0] r_z [STAGES+1][gcd_pkg::ROT_LANES];

    // Input stage: start every lane on the gain-corrected x axis.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int l = 0; l < gcd_pkg::ROT_LANES; l++) begin
                r_x[0][l] <= gcd_pkg::GAIN_Q30;
                r_y[0][l] <= '0;
                r_z[0][l] <= i_angle[l];
            end
        end
    end

    // One micro-rotation per stage.
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic signed [gcd_pkg::ROT_W-1:0] ATAN_G =
            gcd_pkg::ROT_W'(gcd_pkg::ATAN_Q30[g]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[g+1] <= r_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g+1] <= r_side[g];
                for (int l = 0; l < gcd_pkg::ROT_LANES; l++) begin
                    if (!r_z[g][l][gcd_pkg::ROT_W-1]) begin
                        r_x[g+1][l] <= r_x[g][l] - (r_y[g][l] >>> g);
                        r_y[g+1][l] <= r_y[g][l] + (r_x[g][l] >>> g);
                        r_z[g+1][l] <= r_z[g][l] - ATAN_G;
                    end else begin
                        r_x[g+1][l] <= r_x[g][l] + (r_y[g][l] >>> g);
                        r_y[g+1][l] <= r_y[g][l] - (r_x[g][l] >>> g);
                        r_z[g+1][l] <= r_z[g][l] + ATAN_G;
                    end
                end
            end
        end
    end

    // Results of the last stage.
    always_comb begin
        for (int l = 0; l < gcd_pkg::ROT_LANES; l++) begin
            o_cos[l] = r_x[STAGES][l];
            o_sin[l] = r_y[STAGES][l];
        end
    end

    assign o_valid = r_valid[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

`default_nettype wire

### hdl/gcd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module gcd_isqrt #(
    parameter int SIDE_W = 39
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [gcd_pkg::SQ_IN_W-1:0]     i_value,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output logic [gcd_pkg::SQ_OUT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]               o_side
);

    localparam int STEPS = gcd_pkg::SQ_OUT_W;
    localparam int REM_W = gcd_pkg::SQ_OUT_W + 2;
    localparam int TRY_W = REM_W + 2;

    logic                             r_valid [STEPS+1];
    logic [SIDE_W-1:0]                r_side  [STEPS+1];
    logic [gcd_pkg::SQ_IN_W-1:0]      r_bits  [STEPS+1];
    logic [REM_W-1:0]                 r_rem   [STEPS+1];
    logic [gcd_pkg::SQ_OUT_W-1:0]     r_root  [STEPS+1];

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_bits[0] <= i_value;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // Each stage brings down two bits and decides one root bit.
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [TRY_W-1:0] n_rem;
        logic [TRY_W-1:0] n_try;

        assign n_rem = {r_rem[g], r_bits[g][gcd_pkg::SQ_IN_W-1 -: 2]};
        assign n_try = {2'b00, r_root[g], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[g+1] <= r_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g+1] <= r_side[g];
                r_bits[g+1] <= {r_bits[g][gcd_pkg::SQ_IN_W-3:0], 2'b00};
                if (n_rem >= n_try) begin
                    r_rem[g+1]  <= REM_W'(n_rem - n_try);
                    r_root[g+1] <= {r_root[g][gcd_pkg::SQ_OUT_W-2:0], 1'b1};
                end else begin
                    r_rem[g+1]  <= REM_W'(n_rem);
                    r_root[g+1] <= {r_root[g][gcd_pkg::SQ_OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_root  = r_root[STEPS];
    assign o_side  = r_side[STEPS];

endmodule

`default_nettype wire

### hdl/gcd_cordic_vec.sv
// Pipelined vectoring CORDIC computing atan2(y, x) for y >= 0 in Q30 radians.
`timescale 1ns / 1ps
`default_nettype none

module gcd_cordic_vec #(
    parameter int STAGES = 24,
    parameter int SIDE_W = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [gcd_pkg::SQ_OUT_W-1:0]      i_y,
    input  logic signed [gcd_pkg::C_W-1:0]    i_x,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic signed [gcd_pkg::ANG_W-1:0]  o_angle,
    output logic [SIDE_W-1:0]                 o_side
);

    logic                             r_valid [STAGES+1];
    logic                             r_zero  [STAGES+1];
    logic [SIDE_W-1:0]                r_side  [STAGES+1];
    logic signed [gcd_pkg::VEC_W-1:0] r_x [STAGES+1];
    logic signed [gcd_pkg::VEC_W-1:0] r_y [STAGES+1];
    logic signed [gcd_pkg::ANG_W-1:0] r_z [STAGES+1];

    logic signed [gcd_pkg::VEC_W-1:0] y_ext;
    logic signed [gcd_pkg::VEC_W-1:0] x_ext;

    assign y_ext = gcd_pkg::VEC_W'(i_y);
    assign x_ext = gcd_pkg::VEC_W'(i_x);

    // Input stage: fold a negative x into the right half plane by a quarter turn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_zero[0] <= (i_y == '0) && (i_x == '0);
            if (i_x[gcd_pkg::C_W-1]) begin
                r_x[0] <= y_ext;
                r_y[0] <= -x_ext;
                r_z[0] <= gcd_pkg::HALF_PI_Q30;
            end else begin
                r_x[0] <= x_ext;
                r_y[0] <= y_ext;
                r_z[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic signed [gcd_pkg::ANG_W-1:0] ATAN_G =
            gcd_pkg::ANG_W'(gcd_pkg::ATAN_Q30[g]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[g+1] <= r_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g+1] <= r_side[g];
                r_zero[g+1] <= r_zero[g];
                if (!r_y[g][gcd_pkg::VEC_W-1]) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ATAN_G;
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ATAN_G;
                end
            end
        end
    end

    // A zero vector has angle zero.
    assign o_angle = r_zero[STAGES] ? '0 : r_z[STAGES];
    assign o_valid = r_valid[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

`default_nettype wire

### hdl/great_circle_distance_top.sv
// Top level of the great-circle distance pipeline.
//
// Usage: a point pair enters as one transfer on the slave stream; tdata carries first
// latitude, first longitude, second latitude and second longitude, 25-bit signed
// degrees with ANGLE_FRAC_BITS fraction bits. The master stream returns one transfer
// per pair: tdata holds the distance in km times 256, tuser the replaced-field mask.
// The sphere radius is written through i_cfg_wr_en / i_cfg_wr_data while idle.
// The pair passes through the input checks, the longitude-difference fold, degree
// conversion, the three-lane rotation CORDIC, the product stages, a 32-step square
// root, the vectoring CORDIC, the radius scaling and the output rounding.
// Throughput is one pair per cycle; every stage is a register of the same pipeline.
// When the receiver stalls, the whole pipeline holds and o_s_axis_tready drops until
// the output register is taken, so no result is lost or repeated.
// Reset clears all valid bits and sets the radius to 6371 km.
`timescale 1ns / 1ps
`default_nettype none

module great_circle_distance_top #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STAGES   = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // first_latitude, first_longitude, second_latitude, second_longitude, zero fill
    input  logic [103:0] i_s_axis_tdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // distance, zero fill
    output logic [31:0]  o_m_axis_tdata,
    // replaced_mask
    output logic [3:0]   o_m_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data
);

    localparam int                 CW = 35;
    localparam logic signed [CW-1:0] LAT90  = 35'sd90 <<< ANGLE_FRAC_BITS;
    localparam logic signed [CW-1:0] LON180 = 35'sd180 <<< ANGLE_FRAC_BITS;
    localparam logic signed [CW-1:0] LON360 = 35'sd360 <<< ANGLE_FRAC_BITS;
    localparam int                 RAD_W  = 62;
    localparam int                 RAD_SH = ANGLE_FRAC_BITS + 10;
    localparam logic [RAD_W-1:0]   RAD_RND = RAD_W'(1) << (ANGLE_FRAC_BITS + 9);
    localparam int                 DIST_W = 26;
    localparam int                 RP_W   = 49;
    localparam int                 RT_W   = RP_W + 1;
    localparam logic [RT_W-1:0]    DIST_RND = RT_W'(1) << 21;
    localparam int                 ROT_SIDE_W = 5;
    localparam int                 SQ_SIDE_W  = gcd_pkg::C_W + 4;

    // Whole pipeline advances while the output register is free or being taken.
    logic adv;
    logic r_out_valid;

    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    // Radius register.
    logic [15:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd6371;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
        end
    end

    // Stage 1: range check, out-of-range fields replaced by zero.
    logic signed [24:0] lat1_in, lon1_in, lat2_in, lon2_in;
    logic signed [CW-1:0] lat1_ext, lon1_ext, lat2_ext, lon2_ext;
    logic [3:0] n_mask;
    logic       r_s1_valid;
    logic [3:0] r_s1_mask;
    logic signed [24:0] r_lat1, r_lon1, r_lat2, r_lon2;

    assign lat1_in  = i_s_axis_tdata[24:0];
    assign lon1_in  = i_s_axis_tdata[49:25];
    assign lat2_in  = i_s_axis_tdata[74:50];
    assign lon2_in  = i_s_axis_tdata[99:75];
    assign lat1_ext = CW'(lat1_in);
    assign lon1_ext = CW'(lon1_in);
    assign lat2_ext = CW'(lat2_in);
    assign lon2_ext = CW'(lon2_in);

    always_comb begin
        n_mask[0] = (lat1_ext > LAT90)  || (lat1_ext < -LAT90);
        n_mask[1] = (lon1_ext > LON180) || (lon1_ext < -LON180);
        n_mask[2] = (lat2_ext > LAT90)  || (lat2_ext < -LAT90);
        n_mask[3] = (lon2_ext > LON180) || (lon2_ext < -LON180);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mask <= n_mask;
            r_lat1    <= n_mask[0] ? '0 : lat1_in;
            r_lon1    <= n_mask[1] ? '0 : lon1_in;
            r_lat2    <= n_mask[2] ? '0 : lat2_in;
            r_lon2    <= n_mask[3] ? '0 : lon2_in;
        end
    end

    // Stage 2: absolute longitude difference folded into 0..90 degrees.
    logic signed [25:0] dlon_s;
    logic [25:0]        dlon_abs;
    logic signed [CW-1:0] d0, d1, d2;
    logic               n_negcos;
    logic               r_s2_valid;
    logic [3:0]         r_s2_mask;
    logic               r_s2_negcos;
    logic signed [24:0] r_s2_lat1, r_s2_lat2;
    logic [25:0]        r_s2_dlon;

    assign dlon_s   = 26'(r_lon1) - 26'(r_lon2);
    assign dlon_abs = dlon_s[25] ? 26'(-dlon_s) : 26'(dlon_s);

    always_comb begin
        d0       = CW'(dlon_abs);
        d1       = (d0 > LON180) ? (LON360 - d0) : d0;
        n_negcos = d1 > LAT90;
        d2       = n_negcos ? (LON180 - d1) : d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_mask   <= r_s1_mask;
            r_s2_negcos <= n_negcos;
            r_s2_lat1   <= r_lat1;
            r_s2_lat2   <= r_lat2;
            r_s2_dlon   <= d2[25:0];
        end
    end

    // Stage 3: degrees to radians, two partial products per lane.
    logic signed [25:0] deg_src [gcd_pkg::ROT_LANES];
    logic [25:0]        deg_abs [gcd_pkg::ROT_LANES];
    logic               r_s3_valid;
    logic [3:0]         r_s3_mask;
    logic               r_s3_negcos;
    logic               r_s3_neg   [gcd_pkg::ROT_LANES];
    logic [43:0]        r_s3_pp_lo [gcd_pkg::ROT_LANES];
    logic [42:0]        r_s3_pp_hi [gcd_pkg::ROT_LANES];

    always_comb begin
        deg_src[gcd_pkg::LANE_LAT1] = 26'(r_s2_lat1);
        deg_src[gcd_pkg::LANE_LAT2] = 26'(r_s2_lat2);
        deg_src[gcd_pkg::LANE_DLON] = r_s2_dlon;
        for (int l = 0; l < gcd_pkg::ROT_LANES; l++) begin
            deg_abs[l] = deg_src[l][25] ? 26'(-deg_src[l]) : 26'(deg_src[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_mask   <= r_s2_mask;
            r_s3_negcos <= r_s2_negcos;
            for (int l = 0; l < gcd_pkg::ROT_LANES; l++) begin
                r_s3_neg[l]   <= deg_src[l][25];
                r_s3_pp_lo[l] <= 44'(deg_abs[l]) * 44'(gcd_pkg::DEG2RAD_LO);
                r_s3_pp_hi[l] <= 43'(deg_abs[l]) * 43'(gcd_pkg::DEG2RAD_HI);
            end
        end
    end

    // Partial products summed and rounded; the CORDIC input stage registers them.
    logic [RAD_W-1:0]                  rad_sum [gcd_pkg::ROT_LANES];
    logic [RAD_W-1:0]                  rad_mag [gcd_pkg::ROT_LANES];
    logic signed [gcd_pkg::ROT_W-1:0]  rad_z   [gcd_pkg::ROT_LANES];

    always_comb begin
        for (int l = 0; l < gcd_pkg::ROT_LANES; l++) begin
            rad_sum[l] = RAD_W'({r_s3_pp_hi[l], {gcd_pkg::DEG2RAD_LO_W{1'b0}}})
                       + RAD_W'(r_s3_pp_lo[l]) + RAD_RND;
            rad_mag[l] = rad_sum[l] >> RAD_SH;
            rad_z[l]   = r_s3_neg[l] ? -$signed(rad_mag[l][gcd_pkg::ROT_W-1:0])
                                     :  $signed(rad_mag[l][gcd_pkg::ROT_W-1:0]);
        end
    end

    // Sines and cosines of both latitudes and of the longitude difference.
    logic                              rot_valid;
    logic signed [gcd_pkg::ROT_W-1:0]  rot_cos [gcd_pkg::ROT_LANES];
    logic signed [gcd_pkg::ROT_W-1:0]  rot_sin [gcd_pkg::ROT_LANES];
    logic [ROT_SIDE_W-1:0]             rot_side;

    gcd_cordic_rot #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (ROT_SIDE_W)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s3_valid),
        .i_angle (rad_z),
        .i_side  ({r_s3_negcos, r_s3_mask}),
        .o_valid (rot_valid),
        .o_cos   (rot_cos),
        .o_sin   (rot_sin),
        .o_side  (rot_side)
    );

    // Product stage 1: first-level Q30 products.
    logic signed [gcd_pkg::ROT_W-1:0] cd;
    logic signed [gcd_pkg::ROT_W-1:0] cl1, sl1, cl2, sl2, sd;
    logic                             r_p1_valid;
    logic [3:0]                       r_p1_mask;
    logic signed [gcd_pkg::ROT_W-1:0] r_p1_a, r_p1_cs, r_p1_sc, r_p1_ss, r_p1_cc, r_p1_cd;

    assign cl1 = rot_cos[gcd_pkg::LANE_LAT1];
    assign sl1 = rot_sin[gcd_pkg::LANE_LAT1];
    assign cl2 = rot_cos[gcd_pkg::LANE_LAT2];
    assign sl2 = rot_sin[gcd_pkg::LANE_LAT2];
    assign sd  = rot_sin[gcd_pkg::LANE_DLON];
    assign cd  = rot_side[4] ? -rot_cos[gcd_pkg::LANE_DLON] : rot_cos[gcd_pkg::LANE_DLON];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= rot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_mask <= rot_side[3:0];
            r_p1_a    <= gcd_pkg::mulq(cl2, sd);
            r_p1_cs   <= gcd_pkg::mulq(cl1, sl2);
            r_p1_sc   <= gcd_pkg::mulq(sl1, cl2);
            r_p1_ss   <= gcd_pkg::mulq(sl1, sl2);
            r_p1_cc   <= gcd_pkg::mulq(cl1, cl2);
            r_p1_cd   <= cd;
        end
    end

    // Product stage 2: products with the longitude cosine, cross and cosine terms.
    logic signed [gcd_pkg::ROT_W-1:0] t_sc, t_cc;
    logic                             r_p2_valid;
    logic [3:0]                       r_p2_mask;
    logic signed [gcd_pkg::ROT_W-1:0] r_p2_a;
    logic signed [gcd_pkg::C_W-1:0]   r_p2_b, r_p2_c;

    assign t_sc = gcd_pkg::mulq(r_p1_sc, r_p1_cd);
    assign t_cc = gcd_pkg::mulq(r_p1_cc, r_p1_cd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (adv) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_mask <= r_p1_mask;
            r_p2_a    <= r_p1_a;
            r_p2_b    <= gcd_pkg::C_W'(r_p1_cs) - gcd_pkg::C_W'(t_sc);
            r_p2_c    <= gcd_pkg::C_W'(r_p1_ss) + gcd_pkg::C_W'(t_cc);
        end
    end

    // Product stage 3: squares of both terms.
    logic signed [2*gcd_pkg::ROT_W-1:0] sq_a;
    logic signed [2*gcd_pkg::C_W-1:0]   sq_b;
    logic                               r_p3_valid;
    logic [3:0]                         r_p3_mask;
    logic signed [gcd_pkg::C_W-1:0]     r_p3_c;
    logic [gcd_pkg::SQ_IN_W-1:0]        r_p3_aa, r_p3_bb;

    assign sq_a = r_p2_a * r_p2_a;
    assign sq_b = r_p2_b * r_p2_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (adv) begin
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_mask <= r_p2_mask;
            r_p3_c    <= r_p2_c;
            r_p3_aa   <= sq_a[gcd_pkg::SQ_IN_W-1:0];
            r_p3_bb   <= sq_b[gcd_pkg::SQ_IN_W-1:0];
        end
    end

    // Root of the sum of squares; the cosine term and mask travel alongside.
    logic                          sq_valid;
    logic [gcd_pkg::SQ_OUT_W-1:0]  sq_root;
    logic [SQ_SIDE_W-1:0]          sq_side;

    gcd_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_p3_valid),
        .i_value (r_p3_aa + r_p3_bb),
        .i_side  ({r_p3_c, r_p3_mask}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Central angle.
    logic                              vec_valid;
    logic signed [gcd_pkg::ANG_W-1:0]  vec_angle;
    logic [3:0]                        vec_mask;

    gcd_cordic_vec #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (4)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (sq_valid),
        .i_y     (sq_root),
        .i_x     ($signed(sq_side[SQ_SIDE_W-1:4])),
        .i_side  (sq_side[3:0]),
        .o_valid (vec_valid),
        .o_angle (vec_angle),
        .o_side  (vec_mask)
    );

    // Radius stage: clamp a slightly negative angle, scale by the radius.
    logic [gcd_pkg::ANG_W-2:0] ang_pos;
    logic                      r_r1_valid;
    logic [3:0]                r_r1_mask;
    logic [RP_W-1:0]           r_r1_prod;

    assign ang_pos = vec_angle[gcd_pkg::ANG_W-1] ? '0 : vec_angle[gcd_pkg::ANG_W-2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_valid <= 1'b0;
        end else if (adv) begin
            r_r1_valid <= vec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r1_mask <= vec_mask;
            r_r1_prod <= RP_W'(r_radius) * RP_W'(ang_pos);
        end
    end

    // Output register: round to km/256 and saturate.
    logic [RT_W-1:0]   dist_sum;
    logic [RT_W-23:0]  dist_full;
    logic [DIST_W-1:0] n_dist;
    logic [DIST_W-1:0] r_out_dist;
    logic [3:0]        r_out_mask;

    assign dist_sum  = RT_W'(r_r1_prod) + DIST_RND;
    assign dist_full = dist_sum[RT_W-1:22];
    assign n_dist    = (dist_full[RT_W-23:DIST_W] != '0) ? '1 : dist_full[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_dist <= n_dist;
            r_out_mask <= r_r1_mask;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_dist};
    assign o_m_axis_tuser  = r_out_mask;

endmodule

`default_nettype wire
